// ===== rtl/core/ptsp_pkg.sv =====
// Shared types, constants and the arctangent table of the point to servo pulse unit.
// Used by every module under rtl/core except ptsp_checker; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package ptsp_pkg;

	// Vector datapath width: geometry in units of 2^-25 cm plus CORDIC gain headroom
	localparam int VEC_W = 36;
	// Binary angle width: a full turn is 2^32, two extra bits hold sign and overshoot
	localparam int ANG_W = 34;
	localparam int ATAN_ENTRIES = 24;
	localparam int CORDIC_STEPS_DEF = 16;

	// Field widths
	localparam int COORD_W = 14;
	localparam int SIDE_W = 14;
	localparam int PULSE_W = 12;
	localparam int LOWY_W = 30;
	localparam int UANG_W = 33;
	localparam int PROD_W = 44;

	// Geometry constants
	localparam int unsigned ROOT3_INV = 37837;
	localparam logic [SIDE_W-1:0] SIDE_RESET = 14'd4352;

	// Angle and pulse constants
	localparam logic signed [ANG_W-1:0] HALF_TURN = 34'sh0_8000_0000;
	localparam logic [PULSE_W-1:0] PULSE_BASE = 12'd500;
	localparam logic [PULSE_W-1:0] PULSE_CENTER = 12'd1500;
	localparam logic [10:0] PULSE_SCALE = 11'd2000;

	// One mount's vector as it travels through the CORDIC
	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] z;
		logic zero;
	} lane_t;

	// Three mounts: index 0 top, 1 lower left, 2 lower right
	typedef lane_t [2:0] lanes_t;

	// round(atan(2^-i) * 2^32 / (2*pi))
	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'd536870912;
			1: r = 32'd316933406;
			2: r = 32'd167458907;
			3: r = 32'd85004756;
			4: r = 32'd42667331;
			5: r = 32'd21354465;
			6: r = 32'd10679838;
			7: r = 32'd5340245;
			8: r = 32'd2670163;
			9: r = 32'd1335087;
			10: r = 32'd667544;
			11: r = 32'd333772;
			12: r = 32'd166886;
			13: r = 32'd83443;
			14: r = 32'd41722;
			15: r = 32'd20861;
			16: r = 32'd10430;
			17: r = 32'd5215;
			18: r = 32'd2608;
			19: r = 32'd1304;
			20: r = 32'd652;
			21: r = 32'd326;
			22: r = 32'd163;
			23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ptsp_geom.sv =====
// Front end: mount vectors from the target point and the side register, then half-turn
// pre-rotation and zero detect. Three register stages. Depends on ptsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptsp_geom (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 en,
	input  wire                                 in_valid,
	input  wire signed [ptsp_pkg::COORD_W-1:0]  target_x,
	input  wire signed [ptsp_pkg::COORD_W-1:0]  target_y,
	input  wire        [ptsp_pkg::SIDE_W-1:0]   side,
	output logic                                out_valid,
	output ptsp_pkg::lanes_t                    out_lanes
);

	localparam int VW = ptsp_pkg::VEC_W;

	logic                                 valid_s1, valid_s2, valid_s3;
	logic signed [ptsp_pkg::COORD_W-1:0]  x_s1, y_s1;
	logic        [ptsp_pkg::LOWY_W-1:0]   low_s1;
	logic        [ptsp_pkg::SIDE_W-1:0]   side_s1;
	logic signed [VW-1:0]                 vx_s2 [3];
	logic signed [VW-1:0]                 vy_s2 [3];
	ptsp_pkg::lanes_t                     lanes_s3;

	logic signed [VW-1:0] px, py, low_y, top_y, half_s;
	ptsp_pkg::lanes_t     pre;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1: register point and side, form s / (2*sqrt3) in 2^-25 cm units
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= target_x;
			y_s1    <= target_y;
			side_s1 <= side;
			low_s1  <= {16'd0, side} * ptsp_pkg::LOWY_W'(ptsp_pkg::ROOT3_INV);
		end
	end

	// Stage 2: scale to 2^-25 cm and form the three mount-to-point vectors
	always_comb begin
		px     = {{(VW-31){x_s1[ptsp_pkg::COORD_W-1]}}, x_s1, 17'd0};
		py     = {{(VW-31){y_s1[ptsp_pkg::COORD_W-1]}}, y_s1, 17'd0};
		low_y  = {{(VW-ptsp_pkg::LOWY_W){1'b0}}, low_s1};
		top_y  = low_y <<< 1;
		half_s = {{(VW-ptsp_pkg::SIDE_W-16){1'b0}}, side_s1, 16'd0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s2[0] <= px;
			vy_s2[0] <= py - top_y;
			vx_s2[1] <= px + half_s;
			vy_s2[1] <= py + low_y;
			vx_s2[2] <= px - half_s;
			vy_s2[2] <= py + low_y;
		end
	end

	// Stage 3: flag zero vectors, fold the left half plane over by a half turn
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			pre[j].zero = (vx_s2[j] == '0) && (vy_s2[j] == '0);
			if (vx_s2[j][VW-1]) begin
				pre[j].x = -vx_s2[j];
				pre[j].y = -vy_s2[j];
				pre[j].z = vy_s2[j][VW-1] ? -ptsp_pkg::HALF_TURN : ptsp_pkg::HALF_TURN;
			end else begin
				pre[j].x = vx_s2[j];
				pre[j].y = vy_s2[j];
				pre[j].z = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lanes_s3 <= pre;
		end
	end

	assign out_valid = valid_s3;
	assign out_lanes = lanes_s3;

endmodule
`default_nettype wire

// ===== rtl/core/ptsp_cordic_stage.sv =====
// One registered vectoring micro-rotation applied to all three mount lanes.
// Depends on ptsp_pkg for the lane type and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none
module ptsp_cordic_stage #(
	parameter int SHIFT = 0
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                en,
	input  wire                in_valid,
	input  ptsp_pkg::lanes_t   in_lanes,
	output logic               out_valid,
	output ptsp_pkg::lanes_t   out_lanes
);

	localparam int VW = ptsp_pkg::VEC_W;
	localparam logic signed [ptsp_pkg::ANG_W-1:0] STEP_ANGLE =
		{2'b00, ptsp_pkg::atan_turn(SHIFT)};

	logic             valid_s1;
	ptsp_pkg::lanes_t lanes_s1;
	ptsp_pkg::lanes_t rot;
	logic signed [VW-1:0] xs [3];
	logic signed [VW-1:0] ys [3];

	// Turn each vector toward y = 0; a zero y counts as positive
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			xs[j] = in_lanes[j].x >>> SHIFT;
			ys[j] = in_lanes[j].y >>> SHIFT;
			rot[j].zero = in_lanes[j].zero;
			if (!in_lanes[j].y[VW-1]) begin
				rot[j].x = in_lanes[j].x + ys[j];
				rot[j].y = in_lanes[j].y - xs[j];
				rot[j].z = in_lanes[j].z + STEP_ANGLE;
			end else begin
				rot[j].x = in_lanes[j].x - ys[j];
				rot[j].y = in_lanes[j].y + xs[j];
				rot[j].z = in_lanes[j].z - STEP_ANGLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lanes_s1 <= rot;
		end
	end

	assign out_valid = valid_s1;
	assign out_lanes = lanes_s1;

endmodule
`default_nettype wire

// ===== rtl/core/ptsp_pulse.sv =====
// Back end: clamp each angle to a half turn and scale it to a servo pulse in microseconds.
// Two register stages, the second is the output register. Depends on ptsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptsp_pulse (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  en,
	input  wire                                  in_valid,
	input  ptsp_pkg::lanes_t                     in_lanes,
	output logic                                 out_valid,
	output logic [2:0][ptsp_pkg::PULSE_W-1:0]    pulses
);

	localparam int AW = ptsp_pkg::ANG_W;

	logic                              valid_s1, valid_s2;
	logic [ptsp_pkg::UANG_W-1:0]       u_s1 [3];
	logic                              zero_s1 [3];
	logic [2:0][ptsp_pkg::PULSE_W-1:0] pulse_s2;

	logic signed [AW-1:0]          zc [3];
	logic signed [AW-1:0]          zu [3];
	logic [ptsp_pkg::PROD_W-1:0]   prod [3];
	logic [2:0][ptsp_pkg::PULSE_W-1:0] pw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: saturate to [-half turn, +half turn] and shift into [0, full turn]
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (in_lanes[j].z > ptsp_pkg::HALF_TURN) begin
				zc[j] = ptsp_pkg::HALF_TURN;
			end else if (in_lanes[j].z < -ptsp_pkg::HALF_TURN) begin
				zc[j] = -ptsp_pkg::HALF_TURN;
			end else begin
				zc[j] = in_lanes[j].z;
			end
			zu[j] = zc[j] + ptsp_pkg::HALF_TURN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				u_s1[j]    <= zu[j][ptsp_pkg::UANG_W-1:0];
				zero_s1[j] <= in_lanes[j].zero;
			end
		end
	end

	// Stage 2: scale a full turn to 2000 us and add the 500 us base; a point on a mount
	// gives the center pulse
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			prod[j] = {11'd0, u_s1[j]} * {33'd0, ptsp_pkg::PULSE_SCALE};
			if (zero_s1[j]) begin
				pw[j] = ptsp_pkg::PULSE_CENTER;
			end else begin
				pw[j] = ptsp_pkg::PULSE_BASE + prod[j][ptsp_pkg::PROD_W-1:32];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pulse_s2 <= pw;
		end
	end

	assign out_valid = valid_s2;
	assign pulses    = pulse_s2;

endmodule
`default_nettype wire

// ===== rtl/core/point_to_servo_pulse_atan2_unit.sv =====
// Top level of the point to servo pulse unit: side register, geometry front end,
// CORDIC stage chain and pulse back end. Depends on ptsp_pkg, ptsp_geom,
// ptsp_cordic_stage and ptsp_pulse.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------------
//  s_*     | in  | s_tvalid / s_tready    | s_tdata: target_x, target_y (points)
//  m_*     | out | m_tvalid / m_tready    | m_tdata: pulse_top, pulse_left, pulse_right
//  cfg_*   | in  | cfg_valid / cfg_ready  | cfg_data: mount triangle side
//
// One request enters per cycle while s_tready is high. The pipeline has three front-end
// stages, one stage per micro-rotation (min(CORDIC_STEPS, 24) of them), two back-end stages.
// The whole pipeline advances on one enable, high while the output register is empty or
// being taken; while a result waits, every stage holds and s_tready is low.
// Reset clears all valid bits and loads the mount side with 17.0 cm.
// cfg_ready is always high; a write lands in the next cycle.
`timescale 1ns / 1ps
`default_nettype none
module point_to_servo_pulse_atan2_unit #(
	parameter int CORDIC_STEPS = ptsp_pkg::CORDIC_STEPS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // [13:0] target_x, [27:14] target_y, [31:28] zero
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // [11:0] pulse_top, [23:12] pulse_left,
	                               // [35:24] pulse_right, [39:36] zero
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [13:0] cfg_data   // [13:0] mount triangle side
);

	localparam int NSTEPS = (CORDIC_STEPS > ptsp_pkg::ATAN_ENTRIES) ?
		ptsp_pkg::ATAN_ENTRIES : CORDIC_STEPS;

	logic                                en;
	logic [ptsp_pkg::SIDE_W-1:0]         mount_side_q;
	logic                                chain_valid [NSTEPS+1];
	ptsp_pkg::lanes_t                    chain_lanes [NSTEPS+1];
	logic [2:0][ptsp_pkg::PULSE_W-1:0]   pulses;

	// Advance everything unless a finished result is held
	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	// Side register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mount_side_q <= ptsp_pkg::SIDE_RESET;
		end else if (cfg_valid) begin
			mount_side_q <= cfg_data;
		end
	end

	ptsp_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.target_x  ($signed(s_tdata[13:0])),
		.target_y  ($signed(s_tdata[27:14])),
		.side      (mount_side_q),
		.out_valid (chain_valid[0]),
		.out_lanes (chain_lanes[0])
	);

	// Micro-rotation chain
	for (genvar i = 0; i < NSTEPS; i++) begin : g_step
		ptsp_cordic_stage #(
			.SHIFT (i)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (chain_valid[i]),
			.in_lanes  (chain_lanes[i]),
			.out_valid (chain_valid[i+1]),
			.out_lanes (chain_lanes[i+1])
		);
	end

	ptsp_pulse u_pulse (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (chain_valid[NSTEPS]),
		.in_lanes  (chain_lanes[NSTEPS]),
		.out_valid (m_tvalid),
		.pulses    (pulses)
	);

	assign m_tdata = {4'd0, pulses[2], pulses[1], pulses[0]};

endmodule
`default_nettype wire

// ===== rtl/core/ptsp_checker.sv =====
// Port-level checks for the point to servo pulse unit, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module ptsp_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [39:0] m_tdata
);

	// Input is taken exactly when the output side can move
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not track the output stall");

	// A held result stays put
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or dropped");

	// Every pulse stays within 500..2500 us
	a_pulse_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[11:0] >= 12'd500) && (m_tdata[11:0] <= 12'd2500)
			&& (m_tdata[23:12] >= 12'd500) && (m_tdata[23:12] <= 12'd2500)
			&& (m_tdata[35:24] >= 12'd500) && (m_tdata[35:24] <= 12'd2500))
		else $error("pulse out of range");

	// Padding above the pulses is zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:36] == 4'd0)
		else $error("nonzero padding in m_tdata");

endmodule

bind point_to_servo_pulse_atan2_unit ptsp_checker u_ptsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);
`default_nettype wire

// ===== tb/point_to_servo_pulse_atan2_unit_tb.sv =====
// Testbench for point_to_servo_pulse_atan2_unit: drives target points and side writes,
// predicts the three servo pulses with its own CORDIC model or a typed table row and checks every result.
// Depends only on the RTL under rtl/core (ptsp_pkg and the unit's modules).
`timescale 1ns / 1ps
module point_to_servo_pulse_atan2_unit_tb;

	localparam int CORDIC_ROTATIONS = 16;
	localparam int ROTATIONS_USED = (CORDIC_ROTATIONS > 24) ? 24 : CORDIC_ROTATIONS;
	localparam longint HALF_TURN = 64'sd2147483648;
	localparam int ROOT3_RECIP = 37837;          // round(2^16 / sqrt3)
	localparam logic [11:0] PULSE_MIN = 12'd500;
	localparam logic [11:0] PULSE_MID = 12'd1500;
	localparam logic [13:0] SIDE_AT_RESET = 14'd4352;
	localparam int PHASE_POINTS = 110;
	localparam int STALL_AT = 80;
	localparam int STALL_CYCLES = 300;
	localparam int DIRECTED_ROWS = 24;

	typedef struct packed {
		logic [11:0] right;
		logic [11:0] left;
		logic [11:0] top;
	} servo_pulses_t;

	typedef enum bit {ROW_POINT, ROW_SIDE} row_kind_t;

	typedef struct {
		row_kind_t kind;
		int side;
		int x;
		int y;
		bit typed;
		int top;
		int left;
		int right;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [39:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [13:0] cfg_data;

	servo_pulses_t pending_pulses[$];
	logic [13:0] side_now;
	bit no_idle;
	int fault_count;
	int pulses_seen;
	stim_row_t directed_rows [DIRECTED_ROWS];

	// round(atan(2^-i) * 2^32 / (2*pi))
	longint arctan_turns [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	point_to_servo_pulse_atan2_unit #(
		.CORDIC_STEPS(CORDIC_ROTATIONS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Angle of one mount-to-point vector by vectoring CORDIC, mapped to a pulse width
	function automatic logic [11:0] mount_pulse(input longint vx_in, input longint vy_in);
		longint vx;
		longint vy;
		longint ang;
		longint sx;
		longint sy;
		int k;
		vx = vx_in;
		vy = vy_in;
		ang = 0;
		if (vx == 0 && vy == 0)
			return PULSE_MID;
		// fold the left half plane over by a half turn
		if (vx < 0) begin
			ang = (vy >= 0) ? HALF_TURN : -HALF_TURN;
			vx = -vx;
			vy = -vy;
		end
		for (k = 0; k < ROTATIONS_USED; k++) begin
			sx = vx >>> k;
			sy = vy >>> k;
			if (vy >= 0) begin
				vx = vx + sy;
				vy = vy - sx;
				ang = ang + arctan_turns[k];
			end else begin
				vx = vx - sy;
				vy = vy + sx;
				ang = ang - arctan_turns[k];
			end
		end
		if (ang > HALF_TURN)
			ang = HALF_TURN;
		if (ang < -HALF_TURN)
			ang = -HALF_TURN;
		return 12'(longint'(PULSE_MIN) + (((ang + HALF_TURN) * 2000) >>> 32));
	endfunction

	// Pulses for all three mounts, geometry in units of 2^-25 cm
	function automatic servo_pulses_t predict_pulses(input logic signed [13:0] tx,
		input logic signed [13:0] ty, input logic [13:0] side);
		servo_pulses_t p;
		longint px;
		longint py;
		longint s;
		longint low_y;
		longint half_s;
		px = tx;
		py = ty;
		s = side;
		px = px * 131072;
		py = py * 131072;
		low_y = s * ROOT3_RECIP;
		half_s = s * 65536;
		p.top = mount_pulse(px, py - 2 * low_y);
		p.left = mount_pulse(px + half_s, py + low_y);
		p.right = mount_pulse(px - half_s, py + low_y);
		return p;
	endfunction

	function automatic logic signed [13:0] clamp_coord(input int v);
		if (v > 8191)
			return 14'sd8191;
		if (v < -8192)
			return -14'sd8192;
		return 14'(v);
	endfunction

	function automatic int draw_gap();
		return no_idle ? 0 : int'($urandom_range(0, 14));
	endfunction

	// Random target: whole range, near a mount, on a mount's axis lines, or near the origin
	task automatic choose_target(output logic signed [13:0] tx, output logic signed [13:0] ty);
		int s;
		int cx;
		int cy;
		int mount;
		s = side_now;
		mount = $urandom_range(0, 2);
		cx = (mount == 0) ? 0 : ((mount == 1) ? -(s / 2) : s / 2);
		cy = (mount == 0) ? (s * 2 * ROOT3_RECIP) / 131072 : -((s * ROOT3_RECIP) / 131072);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				tx = 14'($urandom);
				ty = 14'($urandom);
			end
			4, 5, 6: begin
				tx = clamp_coord(cx + int'($urandom_range(0, 12)) - 6);
				ty = clamp_coord(cy + int'($urandom_range(0, 12)) - 6);
			end
			7: begin
				tx = clamp_coord(cx);
				ty = 14'($urandom);
			end
			8: begin
				tx = 14'($urandom);
				ty = clamp_coord(cy);
			end
			default: begin
				tx = clamp_coord(int'($urandom_range(0, 16)) - 8);
				ty = clamp_coord(int'($urandom_range(0, 16)) - 8);
			end
		endcase
	endtask

	// Offer one point after a random gap and hold it until the request is taken
	task automatic send_point(input logic signed [13:0] tx, input logic signed [13:0] ty,
		input bit typed, input servo_pulses_t typed_pulses);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, ty, tx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_pulses.push_back(typed ? typed_pulses : predict_pulses(tx, ty, side_now));
	endtask

	// Write the side register once the pipeline has drained
	task automatic write_side(input logic [13:0] value);
		s_tvalid <= 1'b0;
		while (pending_pulses.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		side_now = value;
	endtask

	task automatic check_pulses(input logic [39:0] word);
		servo_pulses_t want;
		if (pending_pulses.size() == 0) begin
			$error("result with no request pending: %h", word);
			fault_count++;
			return;
		end
		want = pending_pulses.pop_front();
		if (word[11:0] !== want.top) begin
			$error("pulse_top: expected %0d, got %0d", want.top, word[11:0]);
			fault_count++;
		end
		if (word[23:12] !== want.left) begin
			$error("pulse_left: expected %0d, got %0d", want.left, word[23:12]);
			fault_count++;
		end
		if (word[35:24] !== want.right) begin
			$error("pulse_right: expected %0d, got %0d", want.right, word[35:24]);
			fault_count++;
		end
	endtask

	// Result side: random stalls, one long hold-off to back the pipeline up
	initial begin
		int gap;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = (pulses_seen == STALL_AT) ? STALL_CYCLES : draw_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			check_pulses(m_tdata);
			pulses_seen++;
		end
	end

	// Stimulus: reset, directed table, then random phases over several side settings
	initial begin
		logic signed [13:0] tx;
		logic signed [13:0] ty;
		servo_pulses_t typed_pulses;
		logic [13:0] phase_side;
		int drain;
		fault_count = 0;
		pulses_seen = 0;
		no_idle = 1'b0;
		side_now = SIDE_AT_RESET;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		directed_rows = '{
			'{ROW_POINT, 0, 0, 0, 0, 0, 0, 0},
			'{ROW_POINT, 0, 8191, 8191, 0, 0, 0, 0},
			'{ROW_POINT, 0, -8192, -8192, 0, 0, 0, 0},
			'{ROW_POINT, 0, 8191, -8192, 0, 0, 0, 0},
			'{ROW_POINT, 0, -8192, 8191, 0, 0, 0, 0},
			'{ROW_POINT, 0, 0, 8191, 0, 0, 0, 0},
			'{ROW_POINT, 0, 0, -8192, 0, 0, 0, 0},
			'{ROW_POINT, 0, -8192, 0, 0, 0, 0, 0},
			'{ROW_POINT, 0, 8191, 0, 0, 0, 0, 0},
			'{ROW_POINT, 0, -1, 0, 0, 0, 0, 0},
			'{ROW_POINT, 0, -1, -1, 0, 0, 0, 0},
			'{ROW_POINT, 0, 0, 2512, 0, 0, 0, 0},
			'{ROW_POINT, 0, 0, 2513, 0, 0, 0, 0},
			'{ROW_POINT, 0, -2176, -1256, 0, 0, 0, 0},
			'{ROW_POINT, 0, 2176, -1257, 0, 0, 0, 0},
			'{ROW_POINT, 0, -2176, 5000, 0, 0, 0, 0},
			'{ROW_POINT, 0, 2176, -8000, 0, 0, 0, 0},
			'{ROW_SIDE, 0, 0, 0, 0, 0, 0, 0},
			// all mounts at the origin: zero vector everywhere
			'{ROW_POINT, 0, 0, 0, 1, 1500, 1500, 1500},
			'{ROW_POINT, 0, -8192, 1, 0, 0, 0, 0},
			'{ROW_POINT, 0, -1, 0, 0, 0, 0, 0},
			'{ROW_SIDE, 16383, 0, 0, 0, 0, 0, 0},
			'{ROW_POINT, 0, -8192, -8192, 0, 0, 0, 0},
			'{ROW_POINT, 0, 8191, 8191, 0, 0, 0, 0}
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// walk the directed table
		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_SIDE) begin
				write_side(14'(directed_rows[r].side));
			end else begin
				typed_pulses.top = 12'(directed_rows[r].top);
				typed_pulses.left = 12'(directed_rows[r].left);
				typed_pulses.right = 12'(directed_rows[r].right);
				send_point(14'(directed_rows[r].x), 14'(directed_rows[r].y),
					directed_rows[r].typed, typed_pulses);
			end
		end

		// random phases: low side, below range, random side in range, high side, back to reset value
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: phase_side = 14'd256;
				1: phase_side = 14'd1;
				2: phase_side = 14'($urandom_range(256, 16383));
				3: phase_side = 14'd16383;
				default: phase_side = SIDE_AT_RESET;
			endcase
			write_side(phase_side);
			no_idle = (phase == 2);
			for (int n = 0; n < PHASE_POINTS; n++) begin
				choose_target(tx, ty);
				send_point(tx, ty, 1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;
		no_idle = 1'b0;

		// drain, then let the pipeline settle
		drain = 0;
		while (pending_pulses.size() != 0 && drain < 10000) begin
			@(posedge clk);
			drain++;
		end
		if (pending_pulses.size() != 0) begin
			$error("%0d results never arrived", pending_pulses.size());
			fault_count++;
		end
		repeat (40) @(posedge clk);
		if (fault_count == 0)
			$display("point_to_servo_pulse_atan2_unit test passed");
		else
			$display("point_to_servo_pulse_atan2_unit test failed");
		$finish;
	end

	// Hard stop if the handshakes hang
	initial begin
		#2000000;
		$display("point_to_servo_pulse_atan2_unit test failed");
		$finish;
	end

endmodule
